/* hdl/rpn_stack_calculator_defines.svh */
// ----------------------------------------------------------------------------
// RPN stack calculator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPN_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("rpn_stack_calculator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RPN_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("rpn_stack_calculator: next-cycle check failed");

`endif

/* hdl/rpn_pkg.sv */
// ----------------------------------------------------------------------------
// RPN calculator package
// Field widths, command and status codes, and the sequencer's control store.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  // Word field widths.
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned KIND_W          = 3;
  localparam int unsigned DEPTH_W         = 7;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned DIV_STEPS       = DATA_W;
  localparam int unsigned CNT_W           = $clog2(DIV_STEPS);

  // Command codes.
  localparam logic [KIND_W-1:0] KIND_PUSH  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUB   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MUL   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIV   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd5;
  localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd6;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

  // Datapath actions, one per control word.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_PUSH,
    ACT_LD_B,
    ACT_ALU,
    ACT_WB,
    ACT_DIV_INIT,
    ACT_DIV_STEP,
    ACT_DIV_FIX,
    ACT_ST_OVER,
    ACT_ST_UNDER,
    ACT_ST_DIVZ,
    ACT_CLEAR,
    ACT_PEEK,
    ACT_EMIT
  } act_e;

  // Jump conditions of the sequencer.
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NO_IN,
    C_DISPATCH,
    C_FULL,
    C_LT2,
    C_IS_DIV,
    C_DIVZ,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef logic [4:0] upc_t;

  // Control word: action, condition, target when true, target when false.
  typedef struct packed {
    act_e  act;
    cond_e cond;
    upc_t  jt;
    upc_t  nt;
  } ucode_t;

  // Control store addresses.
  localparam upc_t U_IDLE    = 5'd0;
  localparam upc_t U_DISP    = 5'd1;
  localparam upc_t U_PUSH    = 5'd2;
  localparam upc_t U_PUSH_WR = 5'd3;
  localparam upc_t U_OVER    = 5'd4;
  localparam upc_t U_BIN     = 5'd5;
  localparam upc_t U_BWAIT   = 5'd6;
  localparam upc_t U_ALU     = 5'd7;
  localparam upc_t U_WB      = 5'd8;
  localparam upc_t U_UNDER   = 5'd9;
  localparam upc_t U_DIV     = 5'd10;
  localparam upc_t U_DSTEP   = 5'd11;
  localparam upc_t U_DFIX    = 5'd12;
  localparam upc_t U_DIVZ    = 5'd13;
  localparam upc_t U_CLEAR   = 5'd14;
  localparam upc_t U_PEEK    = 5'd15;
  localparam upc_t U_NOP     = 5'd16;
  localparam upc_t U_DONE    = 5'd17;

  // Entry point of the routine for each command.
  function automatic upc_t kind_entry(logic [KIND_W-1:0] kind);
    upc_t entry;
    unique case (kind)
      KIND_PUSH:  entry = U_PUSH;
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_DIV:   entry = U_BIN;
      KIND_CLEAR: entry = U_CLEAR;
      KIND_PEEK:  entry = U_PEEK;
      default:    entry = U_NOP;
    endcase
    return entry;
  endfunction

  // Microprogram.
  function automatic ucode_t ucode_rom(upc_t addr);
    ucode_t uw;
    unique case (addr)
      U_IDLE:    uw = '{ACT_LATCH,    C_NO_IN,    U_IDLE,  U_DISP};
      U_DISP:    uw = '{ACT_NONE,     C_DISPATCH, U_IDLE,  U_IDLE};
      U_PUSH:    uw = '{ACT_NONE,     C_FULL,     U_OVER,  U_PUSH_WR};
      U_PUSH_WR: uw = '{ACT_PUSH,     C_ALWAYS,   U_DONE,  U_DONE};
      U_OVER:    uw = '{ACT_ST_OVER,  C_ALWAYS,   U_DONE,  U_DONE};
      U_BIN:     uw = '{ACT_NONE,     C_LT2,      U_UNDER, U_BWAIT};
      U_BWAIT:   uw = '{ACT_LD_B,     C_IS_DIV,   U_DIV,   U_ALU};
      U_ALU:     uw = '{ACT_ALU,      C_ALWAYS,   U_WB,    U_WB};
      U_WB:      uw = '{ACT_WB,       C_ALWAYS,   U_DONE,  U_DONE};
      U_UNDER:   uw = '{ACT_ST_UNDER, C_ALWAYS,   U_DONE,  U_DONE};
      U_DIV:     uw = '{ACT_DIV_INIT, C_DIVZ,     U_DIVZ,  U_DSTEP};
      U_DSTEP:   uw = '{ACT_DIV_STEP, C_DIV_MORE, U_DSTEP, U_DFIX};
      U_DFIX:    uw = '{ACT_DIV_FIX,  C_ALWAYS,   U_WB,    U_WB};
      U_DIVZ:    uw = '{ACT_ST_DIVZ,  C_ALWAYS,   U_DONE,  U_DONE};
      U_CLEAR:   uw = '{ACT_CLEAR,    C_ALWAYS,   U_DONE,  U_DONE};
      U_PEEK:    uw = '{ACT_PEEK,     C_ALWAYS,   U_DONE,  U_DONE};
      U_NOP:     uw = '{ACT_NONE,     C_ALWAYS,   U_DONE,  U_DONE};
      U_DONE:    uw = '{ACT_EMIT,     C_OUT_BUSY, U_DONE,  U_IDLE};
      default:   uw = '{ACT_NONE,     C_ALWAYS,   U_IDLE,  U_IDLE};
    endcase
    return uw;
  endfunction

endpackage

`default_nettype wire

/* hdl/rpn_ram.sv */
// ----------------------------------------------------------------------------
// RPN generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/rpn_stack_calculator.sv */
// ----------------------------------------------------------------------------
// RPN stack calculator
// Reverse Polish calculator on a bounded stack of signed 32-bit words.
// ----------------------------------------------------------------------------
// The block takes one command word at a time (push, add, subtract, multiply,
// divide, clear or peek) and returns one result word per command with the new
// top of stack, the depth and a status code. A small microprogram sequences
// a datapath around a single-port-read stack RAM; a divide runs a restoring
// divider loop that yields one quotient bit per cycle. The second operand
// comes from the RAM's registered read port. The result sits in an output
// register, so a new command is taken while the previous result still waits;
// only a second result blocks. Depth is set by STACK_DEPTH, the stack RAM
// needs no clearing after reset.
`default_nettype none

`include "rpn_stack_calculator_defines.svh"

module rpn_stack_calculator
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic        [KIND_W-1:0]   kind_i,
  input  wire logic signed [DATA_W-1:0]   operand_value_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed      [DATA_W-1:0]   top_value_o,
  output logic             [DEPTH_W-1:0]  stack_depth_o,
  output logic             [STATUS_W-1:0] status_o
);

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned PtrW  = $clog2(STACK_DEPTH + 1);

  // Sequencer and stack control state.
  upc_t              upc_q, upc_d;
  logic [PtrW-1:0]   ptr_q, ptr_d;
  logic              out_valid_q, out_valid_d;

  // Datapath registers.
  logic [KIND_W-1:0]   kind_q;
  logic [DATA_W-1:0]   operand_q;
  logic [DATA_W-1:0]   top_q;
  logic [DATA_W-1:0]   b_q;
  logic [DATA_W-1:0]   r_q;
  logic [DATA_W-1:0]   quo_q;
  logic [DATA_W-1:0]   rem_q;
  logic [DATA_W-1:0]   den_q;
  logic                neg_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [STATUS_W-1:0] st_q;

  // Output word registers.
  logic [DATA_W-1:0]   top_out_q;
  logic [DEPTH_W-1:0]  depth_out_q;
  logic [STATUS_W-1:0] status_out_q;

  ucode_t            uw;
  logic              take;
  logic              accept;
  logic              emit;
  logic              out_busy;
  logic              full;
  logic [PtrW-1:0]   ptr_m2;
  logic [PtrW+DEPTH_W-1:0] depth_ext;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] alu_res;

  // Control word fetch and common decodes.
  assign uw         = ucode_rom(upc_q);
  assign in_ready_o = (upc_q == U_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_busy   = out_valid_q && !out_ready_i;
  assign emit       = (uw.act == ACT_EMIT) && !out_busy;
  assign full       = (ptr_q == PtrW'(STACK_DEPTH));
  assign ptr_m2     = ptr_q - PtrW'(2);
  assign depth_ext  = {{DEPTH_W{1'b0}}, ptr_q};

  // Jump condition select.
  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = !in_valid_i;
      C_FULL:     take = full;
      C_LT2:      take = (ptr_q < PtrW'(2));
      C_IS_DIV:   take = (kind_q == KIND_DIV);
      C_DIVZ:     take = (top_q == '0);
      C_DIV_MORE: take = (cnt_q != CNT_W'(DIV_STEPS - 1));
      C_OUT_BUSY: take = out_busy;
      default:    take = 1'b0;
    endcase
  end

  // Next step, stack pointer and output valid.
  always_comb begin
    if (uw.cond == C_DISPATCH) begin
      upc_d = kind_entry(kind_q);
    end else begin
      upc_d = take ? uw.jt : uw.nt;
    end

    ptr_d = ptr_q;
    case (uw.act)
      ACT_PUSH:  ptr_d = ptr_q + PtrW'(1);
      ACT_WB:    ptr_d = ptr_q - PtrW'(1);
      ACT_CLEAR: ptr_d = '0;
      default:   ptr_d = ptr_q;
    endcase

    out_valid_d = out_busy;
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= U_IDLE;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Stack RAM: push writes at the pointer, writeback replaces the lower operand.
  assign ram_we    = (uw.act == ACT_PUSH) || (uw.act == ACT_WB);
  assign ram_waddr = (uw.act == ACT_PUSH) ? ptr_q[AddrW-1:0] : ptr_m2[AddrW-1:0];
  assign ram_wdata = (uw.act == ACT_PUSH) ? operand_q : r_q;

  rpn_ram #(
    .Width (DATA_W),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_m2[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Add, subtract or multiply of the lower entry by the top entry.
  always_comb begin
    unique case (kind_q)
      KIND_ADD: alu_res = b_q + top_q;
      KIND_SUB: alu_res = b_q - top_q;
      default:  alu_res = b_q * top_q;
    endcase
  end

  // One restoring divide step on the magnitudes.
  assign rem_sh = {rem_q, quo_q[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};

  // Datapath registers, loaded as the current control word says.
  always_ff @(posedge clk_i) begin
    case (uw.act)
      ACT_LATCH: begin
        if (accept) begin
          kind_q    <= kind_i;
          operand_q <= operand_value_i;
          st_q      <= ST_OK;
        end
      end
      ACT_PUSH: begin
        top_q <= operand_q;
      end
      ACT_LD_B: begin
        b_q <= ram_rdata;
      end
      ACT_ALU: begin
        r_q <= alu_res;
      end
      ACT_WB: begin
        top_q <= r_q;
      end
      ACT_DIV_INIT: begin
        quo_q <= b_q[DATA_W-1] ? (DATA_W'(0) - b_q) : b_q;
        den_q <= top_q[DATA_W-1] ? (DATA_W'(0) - top_q) : top_q;
        rem_q <= '0;
        neg_q <= b_q[DATA_W-1] ^ top_q[DATA_W-1];
        cnt_q <= '0;
      end
      ACT_DIV_STEP: begin
        if (!diff[DATA_W]) begin
          rem_q <= diff[DATA_W-1:0];
          quo_q <= {quo_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[DATA_W-1:0];
          quo_q <= {quo_q[DATA_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
      ACT_DIV_FIX: begin
        r_q <= neg_q ? (DATA_W'(0) - quo_q) : quo_q;
      end
      ACT_ST_OVER: begin
        st_q <= ST_OVER;
      end
      ACT_ST_UNDER: begin
        st_q <= ST_UNDER;
      end
      ACT_ST_DIVZ: begin
        st_q <= ST_DIVZ;
      end
      ACT_PEEK: begin
        st_q <= (ptr_q == '0) ? ST_UNDER : ST_OK;
      end
      default: begin
      end
    endcase

    // Result word capture.
    if (emit) begin
      top_out_q    <= (ptr_q == '0) ? '0 : top_q;
      depth_out_q  <= depth_ext[DEPTH_W-1:0];
      status_out_q <= st_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign top_value_o   = top_out_q;
  assign stack_depth_o = depth_out_q;
  assign status_o      = status_out_q;

  // Checks on the sequencer and the stack pointer.
  `RPN_ASSERT_SAME(a_ptr_bound, 1'b1, ptr_q <= PtrW'(STACK_DEPTH))
  `RPN_ASSERT_NEXT(a_accept_dispatch, accept, upc_q == U_DISP)
  `RPN_ASSERT_NEXT(a_wb_pops, upc_q == U_WB, ptr_q == $past(ptr_q) - PtrW'(1))
  `RPN_ASSERT_NEXT(a_div_loop, (upc_q == U_DSTEP) && (cnt_q != CNT_W'(DIV_STEPS - 1)),
                   upc_q == U_DSTEP)

endmodule

`default_nettype wire
